// File: rtl/cdq_pkg.sv
package cdq_pkg;

  localparam int DEPTH_DEFAULT     = 16;
  localparam int WORD_BITS_DEFAULT = 32;

  localparam int              CAP_BITS  = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_DONE       = 2'd0,
    STAT_FULL       = 2'd1,
    STAT_EMPTY      = 2'd2,
    STAT_UNUSED     = 2'd3
  } status_t;

  typedef struct packed {
    logic push_back;
    logic push_front;
    logic pop_front;
    logic pop_back;
  } cell_cmd_t;

endpackage

// File: rtl/cdq_cell.sv
module cdq_cell #(
  parameter int WORD_BITS = cdq_pkg::WORD_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cdq_pkg::cell_cmd_t   cmd,
  input  logic [WORD_BITS-1:0] push_word,
  input  logic [WORD_BITS-1:0] left_data,
  input  logic                 left_valid,
  input  logic [WORD_BITS-1:0] right_data,
  input  logic                 right_valid,
  output logic [WORD_BITS-1:0] data,
  output logic                 valid,
  output logic [WORD_BITS-1:0] tap
);

  logic                 is_last;
  logic                 is_slot;
  logic [WORD_BITS-1:0] data_next;
  logic                 valid_next;

  assign is_last = valid & ~right_valid;
  assign is_slot = ~valid & left_valid;
  assign tap     = is_last ? data : '0;

  always_comb begin
    data_next  = data;
    valid_next = valid;
    if (cmd.push_back) begin
      if (is_slot) begin
        data_next  = push_word;
        valid_next = 1'b1;
      end
    end else if (cmd.push_front) begin
      data_next  = left_data;
      valid_next = left_valid;
    end else if (cmd.pop_front) begin
      data_next  = right_data;
      valid_next = right_valid;
    end else if (cmd.pop_back) begin
      valid_next = valid & right_valid;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

// File: rtl/circular_deque.sv
// Channel   Direction  Handshake                 Payload
// command   in         start, busy               operation, push_value
// result    out        done (one-cycle strobe)   pop_value, status, entry_count,
//                                                is_empty, is_full
// config    in         cfg_valid, cfg_ready      cfg_data (capacity in use)
//
// A command accepted at one edge has its result on the outputs, with done high,
// during the next cycle, so one command can be taken every cycle.
// The front entry sits in the first cell of the chain; every cell moves its word
// to a neighbor or keeps it in each cycle. Reset clears the count, the occupancy
// of every cell and the result strobe, and sets the capacity to 16. The receiver
// cannot stall, so busy stays low.
module circular_deque #(
  parameter int DEPTH     = cdq_pkg::DEPTH_DEFAULT,
  parameter int WORD_BITS = cdq_pkg::WORD_BITS_DEFAULT,
  localparam int CNT_W    = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    operation,
  input  logic signed [WORD_BITS-1:0]   push_value,
  output logic                          done,
  output logic signed [WORD_BITS-1:0]   pop_value,
  output logic [1:0]                    status,
  output logic [CNT_W-1:0]              entry_count,
  output logic                          is_empty,
  output logic                          is_full,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cdq_pkg::CAP_BITS-1:0]  cfg_data
);

  localparam int CMP_W = (CNT_W > cdq_pkg::CAP_BITS) ? CNT_W : cdq_pkg::CAP_BITS;

  logic [cdq_pkg::CAP_BITS-1:0] capacity;
  logic [CMP_W-1:0]             eff_cap;
  logic [CNT_W-1:0]             count;
  logic [CNT_W-1:0]             count_next;
  logic                         accept;
  cdq_pkg::op_t                 op;
  cdq_pkg::status_t             stat_next;
  cdq_pkg::cell_cmd_t           cmd;
  logic [WORD_BITS-1:0]         popped;
  logic [WORD_BITS-1:0]         back_word;
  logic                         at_cap;

  logic [WORD_BITS-1:0] cell_data  [DEPTH];
  logic                 cell_valid [DEPTH];
  logic [WORD_BITS-1:0] cell_tap   [DEPTH];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;
  assign op        = cdq_pkg::op_t'(operation);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= cdq_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  always_comb begin
    eff_cap = CMP_W'(capacity);
    if (capacity == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(capacity) > CMP_W'(DEPTH)) begin
      eff_cap = CMP_W'(DEPTH);
    end
  end

  assign at_cap = CMP_W'(count) >= eff_cap;

  always_comb begin
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_word = back_word | cell_tap[i];
    end
  end

  always_comb begin
    cmd        = '0;
    stat_next  = cdq_pkg::STAT_DONE;
    count_next = count;
    popped     = '0;
    unique case (op)
      cdq_pkg::OP_PUSH_BACK, cdq_pkg::OP_PUSH_FRONT: begin
        if (at_cap) begin
          stat_next = cdq_pkg::STAT_FULL;
        end else begin
          cmd.push_back  = accept && (op == cdq_pkg::OP_PUSH_BACK);
          cmd.push_front = accept && (op == cdq_pkg::OP_PUSH_FRONT);
          count_next     = count + CNT_W'(1);
        end
      end
      cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_BACK: begin
        if (count == '0) begin
          stat_next = cdq_pkg::STAT_EMPTY;
        end else begin
          cmd.pop_front = accept && (op == cdq_pkg::OP_POP_FRONT);
          cmd.pop_back  = accept && (op == cdq_pkg::OP_POP_BACK);
          count_next    = count - CNT_W'(1);
          popped        = (op == cdq_pkg::OP_POP_FRONT) ? cell_data[0] : back_word;
        end
      end
      default: begin
        stat_next = cdq_pkg::STAT_DONE;
      end
    endcase
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_BITS-1:0] left_d;
    logic                 left_v;
    logic [WORD_BITS-1:0] right_d;
    logic                 right_v;

    if (g == 0) begin : g_first
      assign left_d = push_value;
      assign left_v = 1'b1;
    end else begin : g_mid_l
      assign left_d = cell_data[g-1];
      assign left_v = cell_valid[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_d = '0;
      assign right_v = 1'b0;
    end else begin : g_mid_r
      assign right_d = cell_data[g+1];
      assign right_v = cell_valid[g+1];
    end

    cdq_cell #(
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .push_word   (push_value),
      .left_data   (left_d),
      .left_valid  (left_v),
      .right_data  (right_d),
      .right_valid (right_v),
      .data        (cell_data[g]),
      .valid       (cell_valid[g]),
      .tap         (cell_tap[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pop_value   <= popped;
      status      <= stat_next;
      entry_count <= count_next;
      is_empty    <= (count_next == '0);
      is_full     <= CMP_W'(count_next) >= eff_cap;
    end
  end

endmodule

// File: rtl/cdq_checker.sv
module cdq_checker #(
  parameter int DEPTH     = cdq_pkg::DEPTH_DEFAULT,
  parameter int WORD_BITS = cdq_pkg::WORD_BITS_DEFAULT,
  localparam int CNT_W    = $clog2(DEPTH + 1)
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 done,
  input logic [WORD_BITS-1:0] pop_value,
  input logic [1:0]           status,
  input logic [CNT_W-1:0]     entry_count,
  input logic                 is_empty,
  input logic                 is_full
);

  a_strobe: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("Accepted word produced no result.");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("Result strobe without an accepted word.");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (is_empty == (entry_count == '0)))
    else $error("Empty flag disagrees with the count.");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != cdq_pkg::STAT_DONE) |-> (pop_value == '0))
    else $error("Rejected word returned a nonzero value.");

  a_full_reject: assert property (@(posedge clk) disable iff (rst)
    (done && status == cdq_pkg::STAT_FULL) |-> (is_full && $stable(entry_count)))
    else $error("Rejected push changed the count or left full low.");

endmodule

bind circular_deque cdq_checker #(
  .DEPTH     (DEPTH),
  .WORD_BITS (WORD_BITS)
) u_cdq_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .pop_value   (pop_value),
  .status      (status),
  .entry_count (entry_count),
  .is_empty    (is_empty),
  .is_full     (is_full)
);
